/* hw/rtl/fts_pkg.sv */
// fts_pkg: shared types and constants of the task scheduler
// no dependencies
`default_nettype none
package fts_pkg;
  localparam int unsigned TaskSlots    = 8;
  localparam int unsigned PendingDepth = 64;
  localparam int unsigned SlotW = $clog2(TaskSlots);
  localparam int unsigned PendW = $clog2(PendingDepth);
  localparam int unsigned SlotEntryW = 8 + 24 + 32 + 32;
  localparam int unsigned PendEntryW = 8 + 24;
  localparam logic [23:0] TimeoutReset = 24'd5000;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0, FUNC_SUBMIT = 2'd1, FUNC_INTR = 2'd2, FUNC_ERROR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_KILLED = 2'd1, ST_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [23:0] est;
    logic [31:0] arrival;
    logic [31:0] service;
  } slot_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [23:0] est;
  } pend_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] elapsed;
    logic [7:0]  task_id;
    logic [23:0] est_time;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  done_id;
    logic [1:0]  status;
    logic [31:0] finish_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic [31:0] service;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK_RD, S_TICK_RUN, S_BLK, S_FIN_RD, S_FIN, S_ADMIT_RD, S_ADMIT,
    S_OUT
  } state_e;
endpackage
`default_nettype wire

/* hw/rtl/fts_if.sv */
// fts_if: valid/ready channel carrying one word
// depends on fts_pkg
`default_nettype none
interface fts_in_if;
  logic             valid;
  logic             ready;
  fts_pkg::in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fts_out_if;
  logic              valid;
  logic              ready;
  fts_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fts_ram.sv */
// fts_ram: generic single-port-write, registered-read ram
// no dependencies
`default_nettype none
module fts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* hw/rtl/fcfs_task_scheduler_with_blocking.sv */
// fcfs task scheduler with blocking: top level
// depends on fts_pkg, fts_if, fts_ram
// submit (not rejected), interrupt and an idle error are done in the accept cycle
// tick: TICK_RD, TICK_RUN, then FIN_RD, FIN, ADMIT_RD, ADMIT on a finish, then BLK
// throughput: one word in flight; a waiting result word blocks the input
// reset: async active low; queues empty, nothing running, clock 0, timeout 5000
`default_nettype none
module fcfs_task_scheduler_with_blocking (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  fts_in_if.sink        in_if,
  fts_out_if.source     out_if
);
  import fts_pkg::*;

  state_e state_q, state_d;
  in_word_t in_q;
  logic [23:0] timeout_q;
  logic [31:0] clock_q, clock_d;

  // slot usage flags and small queues in flops
  logic [TaskSlots-1:0] used_q, used_d;
  logic [SlotW-1:0] rq_q [TaskSlots];
  logic [SlotW-1:0] rq_head_q, rq_head_d;
  logic [SlotW:0]   rq_cnt_q, rq_cnt_d;
  logic [SlotW-1:0] bq_slot_q [TaskSlots];
  logic [25:0]      bq_time_q [TaskSlots];
  logic [SlotW-1:0] bq_head_q, bq_head_d;
  logic [SlotW:0]   bq_cnt_q, bq_cnt_d;
  logic [SlotW:0]   scan_q, scan_d;
  logic run_q, run_d;
  logic [SlotW-1:0] run_idx_q, run_idx_d;
  logic [PendW-1:0] p_head_q, p_head_d;
  logic [PendW:0]   p_cnt_q, p_cnt_d;
  out_word_t out_q, out_d;
  logic [1:0] reason_q, reason_d;

  // ram ports
  logic s_we; logic [SlotW-1:0] s_wa, s_ra; slot_t s_wd, s_rd;
  logic p_we; logic [PendW-1:0] p_wa; pend_t p_wd, p_rd;

  fts_ram #(.Width(SlotEntryW), .Depth(TaskSlots)) u_slot_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  fts_ram #(.Width(PendEntryW), .Depth(PendingDepth)) u_pend_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_head_q),
    .rdata_o(p_rd));

  // first free slot
  logic free_ok; logic [SlotW-1:0] free_idx;
  always_comb begin
    free_ok = 1'b0; free_idx = '0;
    for (int i = TaskSlots - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_ok = 1'b1; free_idx = SlotW'(i);
      end
    end
  end

  // ready queue and blocked queue pushes (at most one each per cycle)
  logic rq_push; logic [SlotW-1:0] rq_push_v;
  logic bq_push; logic [SlotW-1:0] bq_push_s; logic [25:0] bq_push_t;
  logic [SlotW-1:0] rq_tail, bq_tail;
  logic [SlotW:0] rq_cnt_mid;
  assign rq_tail = rq_head_d + rq_cnt_mid[SlotW-1:0];
  assign bq_tail = bq_head_d + bq_cnt_d[SlotW-1:0] - SlotW'(bq_push);

  logic [31:0] svc_sum, turn;
  logic [25:0] bt;
  assign svc_sum = s_rd.service + 32'(in_q.elapsed);
  assign bt      = bq_time_q[bq_head_q] + 26'(in_q.elapsed);
  assign turn    = clock_q - s_rd.arrival;

  assign in_if.ready  = (state_q == S_IDLE);
  assign out_if.valid = (state_q == S_OUT);
  assign out_if.data  = out_q;

  always_comb begin
    state_d = state_q; clock_d = clock_q; used_d = used_q;
    rq_head_d = rq_head_q; rq_cnt_mid = rq_cnt_q; bq_head_d = bq_head_q;
    bq_cnt_d = bq_cnt_q; scan_d = scan_q; run_d = run_q; run_idx_d = run_idx_q;
    p_head_d = p_head_q; p_cnt_d = p_cnt_q; out_d = out_q; reason_d = reason_q;
    rq_push = 1'b0; rq_push_v = '0; bq_push = 1'b0; bq_push_s = '0; bq_push_t = '0;
    s_we = 1'b0; s_wa = run_idx_q; s_wd = s_rd; s_ra = run_idx_q;
    p_we = 1'b0; p_wa = p_head_q + p_cnt_q[PendW-1:0]; p_wd = {in_q.task_id, in_q.est_time};
    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          reason_d = (func_e'(in_if.data.func) == FUNC_ERROR) ? ST_KILLED : ST_DONE;
          unique case (func_e'(in_if.data.func))
            FUNC_TICK: begin
              clock_d = clock_q + 32'(in_if.data.elapsed);
              if (!run_q && rq_cnt_q != '0) begin
                run_d = 1'b1; run_idx_d = rq_q[rq_head_q];
                rq_head_d = rq_head_q + 1'b1; rq_cnt_mid = rq_cnt_q - 1'b1;
              end
              state_d = S_TICK_RD;
            end
            FUNC_SUBMIT: begin
              if (free_ok && p_cnt_q == '0) begin
                used_d[free_idx] = 1'b1; s_we = 1'b1; s_wa = free_idx;
                s_wd = {in_if.data.task_id, in_if.data.est_time, clock_q, 32'd0};
                rq_push = 1'b1; rq_push_v = free_idx;
              end else if (p_cnt_q < (PendW+1)'(PendingDepth)) begin
                p_we = 1'b1;
                p_wd = {in_if.data.task_id, in_if.data.est_time};
                p_cnt_d = p_cnt_q + 1'b1;
              end else begin
                out_d = {in_if.data.task_id, ST_REJECT, clock_q, 96'd0};
                state_d = S_OUT;
              end
            end
            FUNC_INTR: begin
              if (run_q) begin
                run_d = 1'b0; bq_push = 1'b1; bq_push_s = run_idx_q;
              end
            end
            default: begin
              if (run_q) begin
                reason_d = ST_KILLED; state_d = S_FIN_RD;
              end
            end
          endcase
        end
      end
      S_TICK_RD: state_d = S_TICK_RUN;
      S_TICK_RUN: begin
        scan_d = bq_cnt_q;
        state_d = S_BLK;
        if (run_q) begin
          s_we = 1'b1; s_wd.service = svc_sum;
          if (svc_sum >= 32'(s_rd.est)) begin
            reason_d = ST_DONE; state_d = S_FIN_RD;
          end
        end
      end
      S_BLK: begin
        if (scan_q == '0) begin
          state_d = (reason_q == ST_REJECT) ? S_OUT : S_IDLE;
        end else begin
          scan_d = scan_q - 1'b1;
          bq_head_d = bq_head_q + 1'b1; bq_cnt_d = bq_cnt_q - 1'b1;
          if (bt >= 26'(timeout_q)) begin
            rq_push = 1'b1; rq_push_v = bq_slot_q[bq_head_q];
          end else begin
            bq_push = 1'b1; bq_push_s = bq_slot_q[bq_head_q]; bq_push_t = bt;
          end
        end
      end
      S_FIN_RD: state_d = S_FIN;
      S_FIN: begin
        out_d = {s_rd.id, reason_q, clock_q, turn, turn - s_rd.service, s_rd.service};
        run_d = 1'b0; used_d[run_idx_q] = 1'b0;
        state_d = S_ADMIT_RD;
      end
      S_ADMIT_RD: state_d = S_ADMIT;
      S_ADMIT: begin
        if (p_cnt_q != '0) begin
          used_d[run_idx_q] = 1'b1; s_we = 1'b1;
          s_wd = {p_rd.id, p_rd.est, clock_q, 32'd0};
          rq_push = 1'b1; rq_push_v = run_idx_q;
          p_head_d = p_head_q + 1'b1; p_cnt_d = p_cnt_q - 1'b1;
        end
        scan_d = bq_cnt_q;
        // a finished tick still has to age the blocked queue; mark with reject code
        reason_d = ST_REJECT;
        state_d = (reason_q == ST_DONE) ? S_BLK : S_OUT;
      end
      S_OUT: begin
        if (out_if.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (bq_push) bq_cnt_d = bq_cnt_d + 1'b1;
    rq_cnt_d = rq_cnt_mid + (SlotW+1)'(rq_push);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; clock_q <= '0; used_q <= '0; timeout_q <= TimeoutReset;
      rq_head_q <= '0; rq_cnt_q <= '0; bq_head_q <= '0; bq_cnt_q <= '0;
      scan_q <= '0; run_q <= 1'b0; run_idx_q <= '0; p_head_q <= '0; p_cnt_q <= '0;
      reason_q <= ST_DONE;
    end else begin
      state_q <= state_d; clock_q <= clock_d; used_q <= used_d;
      rq_head_q <= rq_head_d; rq_cnt_q <= rq_cnt_d; bq_head_q <= bq_head_d;
      bq_cnt_q <= bq_cnt_d; scan_q <= scan_d; run_q <= run_d; run_idx_q <= run_idx_d;
      p_head_q <= p_head_d; p_cnt_q <= p_cnt_d; reason_q <= reason_d;
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (in_if.valid && in_if.ready) begin
        in_q <= in_if.data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (rq_push) rq_q[rq_tail] <= rq_push_v;
    if (bq_push) begin
      bq_slot_q[bq_tail] <= bq_push_s; bq_time_q[bq_tail] <= bq_push_t;
    end
  end
endmodule
`default_nettype wire
